### rtl/palette_fade_pixel_mapper_macros.svh
// ----------------------------------------------------------------------------
// palette fade pixel mapper assertion macros
// shared property wrappers, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PALETTE_FADE_PIXEL_MAPPER_MACROS_SVH
`define PALETTE_FADE_PIXEL_MAPPER_MACROS_SVH

// same-cycle implication
`define PFPM_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pfpm: same-cycle check failed");

// next-cycle implication
`define PFPM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pfpm: next-cycle check failed");

`endif

### rtl/pfpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpm_pkg
// types, constants and codes shared by the palette fade pixel mapper
// ----------------------------------------------------------------------------
package pfpm_pkg;

   // palette geometry
   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_ADDR_W      = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int COLOR_W         = 8;
   localparam int REG_Q_W         = 9;

   // fade datapath depth
   localparam int FADE_STAGES = 6;

   // result queue
   localparam int OUT_DEPTH  = 16;
   localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
   localparam int CREDIT_W   = $clog2(OUT_DEPTH + 1);

   // command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   // register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_BLUE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_GREEN    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_RED      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_SHADING  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_STRENGTH = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_OPACITY  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASK_ENABLE   = 3'd6;

   localparam logic [REG_Q_W-1:0] FADE_OPACITY_RESET = 9'd256;

   // luma weights, sum 1000
   localparam logic [17:0] LUMA_W_B = 18'd114;
   localparam logic [17:0] LUMA_W_G = 18'd587;
   localparam logic [17:0] LUMA_W_R = 18'd299;

   // fixed-point constants of the fade math
   localparam logic signed [28:0] SCALE_UNIT = 29'sd128000;      // 1.0 in luma units
   localparam logic signed [37:0] SCALE_DEN  = 38'sd32768000;    // 256 * 128000
   localparam logic signed [48:0] CH_DEN     = 49'sd8388608000;  // 125 << 26
   localparam logic signed [48:0] CH_HALF    = 49'sd4194304000;
   localparam logic signed [48:0] CH_HI      = 49'sd2139095040000; // 255 * CH_DEN
   localparam logic signed [27:0] ALPHA_ONE  = 28'sd16711680;    // 255 << 16
   localparam logic signed [27:0] ALPHA_HALF = 28'sd32768;
   localparam logic signed [27:0] ALPHA_MUL  = 28'sd255;
   localparam logic [30:0]        RECIP_125  = 31'd33555;        // ceil(2^22 / 125)
   localparam int                 RECIP_SH   = 22;

   localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [COLOR_W-1:0] CHAN_MAX     = 8'hFF;

   typedef enum logic [1:0] {
      MODE_CLEAR,
      MODE_FADE,
      MODE_SOLID
   } mode_type;

   typedef struct packed {
      logic               highlight;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } palette_word_type;

   typedef struct packed {
      logic [COLOR_W-1:0] fade_blue;
      logic [COLOR_W-1:0] fade_green;
      logic [COLOR_W-1:0] fade_red;
      logic [REG_Q_W-1:0] fade_shading;
      logic [REG_Q_W-1:0] fade_strength;
      logic [REG_Q_W-1:0] fade_opacity;
      logic               mask_enable;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic eoi;
      logic clear;
   } stage_ctl_type;

   typedef struct packed {
      logic [31:0] pixel_argb;
      logic        end_of_image_out;
   } out_beat_type;

   function automatic logic index_in_range(input logic [COLOR_W-1:0] idx);
      return 32'(idx) < 32'(PALETTE_ENTRIES);
   endfunction

endpackage

### rtl/pfpm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpm channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface pfpm_req_if;
   import pfpm_pkg::*;

   logic               valid;
   logic               ready;
   logic               cmd;
   logic [COLOR_W-1:0] color_index;
   logic [COLOR_W-1:0] entry_blue;
   logic [COLOR_W-1:0] entry_green;
   logic [COLOR_W-1:0] entry_red;
   logic               entry_highlight;
   logic               end_of_image_in;

   modport source (
      output valid, cmd, color_index, entry_blue, entry_green, entry_red,
             entry_highlight, end_of_image_in,
      input  ready
   );
   modport sink (
      input  valid, cmd, color_index, entry_blue, entry_green, entry_red,
             entry_highlight, end_of_image_in,
      output ready
   );
endinterface

interface pfpm_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_argb;
   logic        end_of_image_out;

   modport source (output valid, pixel_argb, end_of_image_out, input ready);
   modport sink   (input valid, pixel_argb, end_of_image_out, output ready);
endinterface

### rtl/pfpm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pfpm_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/pfpm_fade_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpm_fade_pipe
// six-stage colour fade datapath, one pixel per cycle
// ----------------------------------------------------------------------------
module pfpm_fade_pipe (
   input  logic                        clock,
   input  logic                        reset,
   input  pfpm_pkg::cfg_type           cfg,
   input  pfpm_pkg::stage_ctl_type     in_ctl,
   input  pfpm_pkg::palette_word_type  in_word,
   output logic                        out_push,
   output pfpm_pkg::out_beat_type      out_beat
);
   import pfpm_pkg::*;

   // control chain
   logic           vld_ff  [FADE_STAGES];
   logic           eoi_ff  [FADE_STAGES];
   mode_type       mode_ff [FADE_STAGES];
   logic [COLOR_W-1:0] col_ff [FADE_STAGES][3];

   // stage payloads
   logic        [17:0] luma1_ff;
   logic signed [18:0] am1_ff;
   logic signed [28:0] scale2_ff;
   logic signed [27:0] an2_ff;
   logic signed [37:0] t3_ff [3];
   logic [COLOR_W-1:0] a_ff [4];   // alpha from stage 3 to 6
   logic signed [47:0] p4_ff [3];
   logic signed [48:0] num5_ff [3];
   logic               lo6_ff [3];
   logic               hi6_ff [3];
   logic [14:0]        v6_ff [3];

   // next values
   logic [COLOR_W-1:0] in_col [3];
   mode_type           mode_in;
   logic        [17:0] luma1_in;
   logic signed [18:0] am1_in;
   logic signed [9:0]  opac_off;
   logic signed [28:0] inv_s, shade_s, luma_s, scale2_in;
   logic signed [27:0] an2_in, an_round;
   logic [COLOR_W-1:0] a3_in;
   logic signed [37:0] scale_x, fade_x [3], t3_in [3];
   logic signed [47:0] p4_in [3];
   logic signed [48:0] num5_in [3], num_round [3];
   logic [30:0]        recip [3];
   logic [COLOR_W-1:0] lane_out [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FADE_STAGES; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_ctl.valid;
         for (int i = 1; i < FADE_STAGES; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // stage 1: palette word, luma, alpha product
   always_comb begin
      in_col[0] = in_word.blue;
      in_col[1] = in_word.green;
      in_col[2] = in_word.red;
      if (in_ctl.clear) begin
         mode_in = MODE_CLEAR;
      end else if (cfg.mask_enable && !in_word.highlight) begin
         mode_in = MODE_FADE;
      end else begin
         mode_in = MODE_SOLID;
      end
      luma1_in = LUMA_W_B * 18'(in_word.blue) + LUMA_W_G * 18'(in_word.green)
               + LUMA_W_R * 18'(in_word.red);
      opac_off = $signed({1'b0, cfg.fade_opacity}) - 10'sd256;
      am1_in   = 19'(opac_off) * 19'($signed({1'b0, cfg.fade_strength}));
   end

   // stage 2: shading scale, alpha numerator
   always_comb begin
      shade_s   = 29'($signed({1'b0, cfg.fade_shading}));
      inv_s     = 29'sd256 - shade_s;
      luma_s    = 29'($signed({1'b0, luma1_ff}));
      scale2_in = inv_s * SCALE_UNIT + shade_s * luma_s;
      an2_in    = ALPHA_ONE + 28'(am1_ff) * ALPHA_MUL;
   end

   // stage 3: per-lane target minus source, alpha clamp and round
   always_comb begin
      scale_x = 38'(scale2_ff);
      fade_x[0] = 38'($signed({1'b0, cfg.fade_blue}));
      fade_x[1] = 38'($signed({1'b0, cfg.fade_green}));
      fade_x[2] = 38'($signed({1'b0, cfg.fade_red}));
      for (int k = 0; k < 3; k++) begin
         t3_in[k] = fade_x[k] * scale_x
                  - 38'($signed({1'b0, col_ff[1][k]})) * SCALE_DEN;
      end
      an_round = an2_ff + ALPHA_HALF;
      if (an2_ff <= 28'sd0) begin
         a3_in = '0;
      end else if (an2_ff >= ALPHA_ONE) begin
         a3_in = CHAN_MAX;
      end else begin
         a3_in = an_round[23:16];
      end
   end

   // stage 4 and 5: weight by strength, add source back
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         p4_in[k]   = 48'(t3_ff[k]) * 48'($signed({1'b0, cfg.fade_strength}));
         num5_in[k] = 49'(p4_ff[k]) + 49'($signed({1'b0, col_ff[3][k]})) * CH_DEN;
      end
   end

   // stage 6 prep: clamp flags and coarse quotient
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         num_round[k] = num5_ff[k] + CH_HALF;
      end
   end

   always_ff @(posedge clock) begin
      // stage 1
      eoi_ff[0]  <= in_ctl.eoi;
      mode_ff[0] <= mode_in;
      col_ff[0]  <= in_col;
      luma1_ff   <= luma1_in;
      am1_ff     <= am1_in;
      // stage 2
      scale2_ff  <= scale2_in;
      an2_ff     <= an2_in;
      // stage 3
      t3_ff      <= t3_in;
      a_ff[0]    <= a3_in;
      // stage 4
      p4_ff      <= p4_in;
      // stage 5
      num5_ff    <= num5_in;
      // stage 6
      for (int k = 0; k < 3; k++) begin
         lo6_ff[k] <= num5_ff[k] <= 49'sd0;
         hi6_ff[k] <= num5_ff[k] >= CH_HI;
         v6_ff[k]  <= num_round[k][40:26];
      end
      for (int i = 1; i < FADE_STAGES; i++) begin
         eoi_ff[i]  <= eoi_ff[i-1];
         mode_ff[i] <= mode_ff[i-1];
         col_ff[i]  <= col_ff[i-1];
      end
      for (int i = 1; i < 4; i++) begin
         a_ff[i] <= a_ff[i-1];
      end
   end

   // final: divide by 125 through reciprocal, pick the result form
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         recip[k] = 31'(v6_ff[k]) * RECIP_125;
         if (lo6_ff[k]) begin
            lane_out[k] = '0;
         end else if (hi6_ff[k]) begin
            lane_out[k] = CHAN_MAX;
         end else begin
            lane_out[k] = recip[k][RECIP_SH+7:RECIP_SH];
         end
      end
      out_beat.end_of_image_out = eoi_ff[FADE_STAGES-1];
      case (mode_ff[FADE_STAGES-1])
         MODE_CLEAR: out_beat.pixel_argb = '0;
         MODE_FADE:  out_beat.pixel_argb = {a_ff[3], lane_out[2], lane_out[1], lane_out[0]};
         MODE_SOLID: out_beat.pixel_argb = {ALPHA_OPAQUE, col_ff[FADE_STAGES-1][2],
                                            col_ff[FADE_STAGES-1][1],
                                            col_ff[FADE_STAGES-1][0]};
         default:    out_beat.pixel_argb = '0;
      endcase
   end

   assign out_push = vld_ff[FADE_STAGES-1];

endmodule

### rtl/pfpm_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpm_out_fifo
// result queue that decouples the fade pipeline from the response channel
// ----------------------------------------------------------------------------
module pfpm_out_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  pfpm_pkg::out_beat_type        push_beat,
   output logic [pfpm_pkg::CREDIT_W-1:0] level,
   pfpm_rsp_if.source                    rsp_bus
);
   import pfpm_pkg::*;

   out_beat_type         mem_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CREDIT_W-1:0]  level_ff, level_in;
   logic                 pop;

   function automatic logic [OUT_PTR_W-1:0] ptr_next(input logic [OUT_PTR_W-1:0] p);
      return (p == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : p + OUT_PTR_W'(1);
   endfunction

   assign pop = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      level_in  = level_ff + CREDIT_W'(push) - CREDIT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_beat;
      end
   end

   assign rsp_bus.valid            = level_ff != '0;
   assign rsp_bus.pixel_argb       = mem_ff[rd_ptr_ff].pixel_argb;
   assign rsp_bus.end_of_image_out = mem_ff[rd_ptr_ff].end_of_image_out;
   assign level                    = level_ff;

endmodule

### rtl/palette_fade_pixel_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_fade_pixel_mapper
// 256-entry palette lookup with optional luma-shaded colour fade
// ----------------------------------------------------------------------------
// Sustains one request beat per clock while ready is high; loads and pixels
// mix freely. A load beat writes one entry of the palette ram and returns
// nothing; a pixel beat returns one ARGB beat through the ram read register,
// six stages of fade math and the result queue. Beats leave in order. The
// 16-entry result queue holds finished pixels while the response side stalls;
// req_bus.ready drops only when 16 pixels are outstanding (in flight plus
// queued), so throughput is set by the response side alone. A load followed
// at once by a pixel of the same index sees the new entry. There is no
// clearing pass after reset; reading a never-loaded entry gives undefined
// colour. Registers are written through csr_* and should change only while
// no pixel is outstanding.
// ----------------------------------------------------------------------------
`include "palette_fade_pixel_mapper_macros.svh"

module palette_fade_pixel_mapper (
   input  logic                             clock,
   input  logic                             reset,
   pfpm_req_if.sink                         req_bus,
   pfpm_rsp_if.source                       rsp_bus,
   input  logic                             csr_wr_en,
   input  logic [pfpm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pfpm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pfpm_pkg::*;

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   // accept and credit tracking
   logic                req_take;
   logic                pixel_take;
   logic                load_take;
   logic                rsp_take;
   logic [CREDIT_W-1:0] credit_ff, credit_in;

   // ram side
   palette_word_type    wr_word;
   palette_word_type    rd_word;
   logic [PAL_ADDR_W-1:0] pal_addr;

   // stage 0 control, aligned with ram read data
   stage_ctl_type       s0_ff, s0_in;

   // fade pipe to result queue
   logic                fifo_push;
   out_beat_type        fifo_beat;
   logic [CREDIT_W-1:0] fifo_level;

   // ---------------------------------------------------------------- csr
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FADE_BLUE:     cfg_in.fade_blue     = csr_wdata[COLOR_W-1:0];
            CSR_FADE_GREEN:    cfg_in.fade_green    = csr_wdata[COLOR_W-1:0];
            CSR_FADE_RED:      cfg_in.fade_red      = csr_wdata[COLOR_W-1:0];
            CSR_FADE_SHADING:  cfg_in.fade_shading  = csr_wdata[REG_Q_W-1:0];
            CSR_FADE_STRENGTH: cfg_in.fade_strength = csr_wdata[REG_Q_W-1:0];
            CSR_FADE_OPACITY:  cfg_in.fade_opacity  = csr_wdata[REG_Q_W-1:0];
            CSR_MASK_ENABLE:   cfg_in.mask_enable   = csr_wdata[0];
            default:           cfg_in = cfg_ff;   // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{fade_blue: '0, fade_green: '0, fade_red: '0,
                     fade_shading: '0, fade_strength: '0,
                     fade_opacity: FADE_OPACITY_RESET, mask_enable: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------- accept
   // ready only depends on the credit register, never on rsp_bus.ready
   assign req_bus.ready = credit_ff < CREDIT_W'(OUT_DEPTH);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign pixel_take    = req_take && (req_bus.cmd == CMD_PIXEL);
   assign load_take     = req_take && (req_bus.cmd == CMD_LOAD)
                        && index_in_range(req_bus.color_index);
   assign rsp_take      = rsp_bus.valid && rsp_bus.ready;

   // one credit per pixel from accept until its response beat leaves
   assign credit_in = credit_ff + CREDIT_W'(pixel_take) - CREDIT_W'(rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   // ---------------------------------------------------------------- palette
   assign pal_addr = req_bus.color_index[PAL_ADDR_W-1:0];
   assign wr_word  = '{highlight: req_bus.entry_highlight, red: req_bus.entry_red,
                       green: req_bus.entry_green, blue: req_bus.entry_blue};

   // loads and pixels share the accept slot, so a write and a read never
   // land in the same cycle; a read the cycle after a write sees the write
   pfpm_ram #(
      .WIDTH ($bits(palette_word_type)),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (load_take),
      .wr_addr (pal_addr),
      .wr_data (wr_word),
      .rd_en   (pixel_take),
      .rd_addr (pal_addr),
      .rd_data (rd_word)
   );

   // index zero and indexes past the palette come out transparent
   always_comb begin
      s0_in.valid = pixel_take;
      s0_in.eoi   = req_bus.end_of_image_in;
      s0_in.clear = (req_bus.color_index == '0) || !index_in_range(req_bus.color_index);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
      end else begin
         s0_ff.valid <= s0_in.valid;
      end
      s0_ff.eoi   <= s0_in.eoi;
      s0_ff.clear <= s0_in.clear;
   end

   // ---------------------------------------------------------------- fade math
   pfpm_fade_pipe u_fade (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_ctl   (s0_ff),
      .in_word  (rd_word),
      .out_push (fifo_push),
      .out_beat (fifo_beat)
   );

   // ---------------------------------------------------------------- results
   pfpm_out_fifo u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_beat (fifo_beat),
      .level     (fifo_level),
      .rsp_bus   (rsp_bus)
   );

   // ---------------------------------------------------------------- checks
   // credits cover every queued beat, so the queue can never overflow
   `PFPM_ASSERT_NOW(a_queue_room, fifo_push, fifo_level < CREDIT_W'(OUT_DEPTH))
   // queued beats never outnumber outstanding pixels
   `PFPM_ASSERT_NOW(a_level_within_credit, 1'b1, fifo_level <= credit_ff)
   // a pixel accept with no response leaving raises the credit by one
   `PFPM_ASSERT_NEXT(a_credit_step, pixel_take && !rsp_take,
                     credit_ff == $past(credit_ff) + CREDIT_W'(1))

endmodule
